FILE: src/nplb_pkg.sv
package nplb_pkg;

  // Field widths of the request and result channels
  localparam int OP_W       = 2;
  localparam int PRICE_W    = 48;
  localparam int VOLUME_W   = 48;
  localparam int AMOUNT_W   = 63;
  localparam int SCALE_W    = 40;
  localparam int RECEIVED_W = 64;
  localparam int LEVELS_W   = 4;

  // Defaults for the top-level parameters
  localparam int LEVEL_DEPTH_DEF = 10;
  localparam int PRICE_WIDTH_DEF = 48;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(64'd100000000);

  // Operation codes
  localparam logic [OP_W-1:0] OP_ASK_UPD = 2'd0;
  localparam logic [OP_W-1:0] OP_BID_UPD = 2'd1;
  localparam logic [OP_W-1:0] OP_SELL    = 2'd2;
  localparam logic [OP_W-1:0] OP_BUY     = 2'd3;

endpackage

FILE: src/nplb_in_if.sv
interface nplb_in_if;
  logic                        valid;
  logic                        ready;
  logic [nplb_pkg::OP_W-1:0]     operation;
  logic [nplb_pkg::PRICE_W-1:0]  price;
  logic [nplb_pkg::VOLUME_W-1:0] volume;
  logic [nplb_pkg::AMOUNT_W-1:0] amount;

  modport source (output valid, operation, price, volume, amount, input ready);
  modport sink   (input valid, operation, price, volume, amount, output ready);
endinterface

FILE: src/nplb_out_if.sv
interface nplb_out_if;
  logic                          valid;
  logic                          ready;
  logic [nplb_pkg::RECEIVED_W-1:0] received;
  logic [nplb_pkg::LEVELS_W-1:0]   bid_levels;
  logic [nplb_pkg::LEVELS_W-1:0]   ask_levels;

  modport source (output valid, received, bid_levels, ask_levels, input ready);
  modport sink   (input valid, received, bid_levels, ask_levels, output ready);
endinterface

FILE: src/top_n_price_level_book_unit.sv
// Top-N price-level book.
// Request channel in_ch: an ask or bid level update (price, volume; volume
// zero removes the level) or a sell/buy conversion of amount through the
// bids/asks. Each request gives exactly one result on out_ch: the converted
// amount (zero for updates, saturated at 64 bits) and both level counts.
// cfg_we/cfg_wdata write price_scale; write it only while the block is idle.
// An update scans linearly for the level position, one compare per cycle,
// then applies the change. A conversion walks the levels one at a time:
// each level goes through a shared 64x16 multiplier and a shared
// restoring divider that resolves one quotient bit per cycle.
// One request is in work at a time; in_ch.ready is high only when idle.
// The result sits in an output register, so the next request is accepted
// while the receiver stalls; the block only waits when a second result is
// done before the first has been taken.
// Reset empties both tables and restores price_scale to 100000000; level
// storage itself is not cleared, only the counts.
module top_n_price_level_book_unit #(
  parameter int LEVEL_DEPTH = nplb_pkg::LEVEL_DEPTH_DEF,
  parameter int PRICE_WIDTH = nplb_pkg::PRICE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  nplb_in_if.sink                      in_ch,
  nplb_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [nplb_pkg::SCALE_W-1:0] cfg_wdata
);
  import nplb_pkg::*;

  localparam int PE  = (PRICE_WIDTH < PRICE_W) ? PRICE_WIDTH : PRICE_W;
  localparam int CW  = $clog2(LEVEL_DEPTH + 1);
  localparam int IW  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int BW  = 48;            // multiplier b operand and divisor width
  localparam int AW  = 64;            // multiplier a operand width
  localparam int PW  = AW + BW;       // product width
  localparam int DGW = 16;            // multiplier digit width
  localparam int NDG = BW / DGW;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_APPLY, S_LEVEL, S_MUL, S_TAKE, S_DIVSTART, S_DIV,
    S_ACC, S_DONE
  } state_t;

  state_t state_r, ret_r;

  logic [SCALE_W-1:0]  scale_r;
  logic [PE-1:0]       prc_r [2][LEVEL_DEPTH];
  logic [VOLUME_W-1:0] vol_r [2][LEVEL_DEPTH];
  logic [CW-1:0]       cnt_r [2];

  logic                side_r;     // 1: bids, 0: asks
  logic                conv_r;     // conversion in progress
  logic [PE-1:0]       p_r;
  logic [VOLUME_W-1:0] v_r;
  logic [AMOUNT_W-1:0] left_r;
  logic [CW-1:0]       idx_r;
  logic [CW-1:0]       lvl_r;      // levels still to walk
  logic [PE-1:0]       lp_r;       // price of current level
  logic [RECEIVED_W-1:0] got_r;

  logic [AW-1:0]       mul_a_r;
  logic [BW-1:0]       mul_b_r;
  logic [PW-1:0]       acc_r;
  logic [1:0]          mul_cnt_r;

  logic [BW-1:0]       div_d_r;
  logic [BW-1:0]       rem_r;
  logic [AW-1:0]       num_r;
  logic [RECEIVED_W-1:0] quo_r;
  logic [6:0]          div_cnt_r;

  logic                out_valid_r;
  logic [RECEIVED_W-1:0] out_rcv_r;
  logic [LEVELS_W-1:0] out_bid_r, out_ask_r;

  // Scan compare and level hit
  logic [CW-1:0] n_cur;
  logic [PE-1:0] prc_at_idx;
  logic          scan_more;
  logic          hit;
  assign n_cur      = cnt_r[side_r];
  assign prc_at_idx = prc_r[side_r][idx_r[IW-1:0]];
  assign scan_more  = (idx_r < n_cur) && (prc_at_idx < p_r);
  assign hit        = (idx_r < n_cur) && (prc_at_idx == p_r);

  // Neighbor taps for shifting a table
  logic [PE-1:0]       prc_dn [LEVEL_DEPTH];
  logic [PE-1:0]       prc_up [LEVEL_DEPTH];
  logic [VOLUME_W-1:0] vol_dn [LEVEL_DEPTH];
  logic [VOLUME_W-1:0] vol_up [LEVEL_DEPTH];
  always_comb begin
    for (int i = 0; i < LEVEL_DEPTH; i++) begin
      prc_dn[i] = prc_r[side_r][i];
      vol_dn[i] = vol_r[side_r][i];
      prc_up[i] = prc_r[side_r][i];
      vol_up[i] = vol_r[side_r][i];
      if (i > 0) begin
        prc_dn[i] = prc_r[side_r][i-1];
        vol_dn[i] = vol_r[side_r][i-1];
      end
      if (i + 1 < LEVEL_DEPTH) begin
        prc_up[i] = prc_r[side_r][i+1];
        vol_up[i] = vol_r[side_r][i+1];
      end
    end
  end

  // Current level for conversion
  logic [PE-1:0]       lvl_prc;
  logic [VOLUME_W-1:0] lvl_vol;
  logic [AMOUNT_W-1:0] sell_take;
  assign lvl_prc   = prc_r[side_r][idx_r[IW-1:0]];
  assign lvl_vol   = vol_r[side_r][idx_r[IW-1:0]];
  assign sell_take = (AMOUNT_W'(lvl_vol) < left_r) ? AMOUNT_W'(lvl_vol) : left_r;

  // Capacity clamp for buys
  logic [AMOUNT_W-1:0] buy_take;
  assign buy_take = (acc_r > PW'(left_r)) ? left_r : acc_r[AMOUNT_W-1:0];

  // Multiplier step: one 64x16 partial product per cycle
  logic [AW+DGW-1:0] pp;
  assign pp = mul_a_r * mul_b_r[BW-1 -: DGW];

  // Divider step: one quotient bit per cycle
  logic [BW:0] trial;
  logic        q_bit;
  assign trial = {rem_r, num_r[AW-1]};
  assign q_bit = (trial >= {1'b0, div_d_r});

  logic [RECEIVED_W:0] sum;
  assign sum = {1'b0, got_r} + {1'b0, quo_r};

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.received   = out_rcv_r;
  assign out_ch.bid_levels = out_bid_r;
  assign out_ch.ask_levels = out_ask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      scale_r     <= SCALE_RESET;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      out_valid_r <= 1'b0;
      conv_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        scale_r <= cfg_wdata;
      end

      // Output valid: set when a result is loaded, cleared once taken
      if ((state_r == S_DONE) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            p_r    <= in_ch.price[PE-1:0];
            v_r    <= in_ch.volume;
            left_r <= in_ch.amount;
            got_r  <= '0;
            side_r <= (in_ch.operation == OP_BID_UPD) || (in_ch.operation == OP_SELL);
            idx_r  <= (in_ch.operation == OP_SELL) ? cnt_r[1] - CW'(1) : '0;
            if ((in_ch.operation == OP_ASK_UPD) || (in_ch.operation == OP_BID_UPD)) begin
              conv_r  <= 1'b0;
              state_r <= (in_ch.price[PE-1:0] == '0) ? S_DONE : S_SCAN;
            end else begin
              conv_r  <= 1'b1;
              lvl_r   <= (in_ch.operation == OP_SELL) ? cnt_r[1] : cnt_r[0];
              state_r <= S_LEVEL;
            end
          end
        end

        // Find first level whose price is not below the request price
        S_SCAN: begin
          if (scan_more) begin
            idx_r <= idx_r + CW'(1);
          end else begin
            state_r <= S_APPLY;
          end
        end

        // Remove, set or insert in one pass over all entries
        S_APPLY: begin
          if (v_r == '0) begin
            if (hit) begin
              for (int i = 0; i < LEVEL_DEPTH; i++) begin
                if ((CW'(i) >= idx_r) && (CW'(i + 1) < n_cur)) begin
                  prc_r[side_r][i] <= prc_up[i];
                  vol_r[side_r][i] <= vol_up[i];
                end
              end
              cnt_r[side_r] <= n_cur - CW'(1);
            end
          end else if (hit) begin
            vol_r[side_r][idx_r[IW-1:0]] <= v_r;
          end else if ((n_cur < CW'(LEVEL_DEPTH)) || !side_r) begin
            // insert; a full ask table loses its highest level
            for (int i = 0; i < LEVEL_DEPTH; i++) begin
              if (CW'(i) > idx_r) begin
                prc_r[side_r][i] <= prc_dn[i];
                vol_r[side_r][i] <= vol_dn[i];
              end else if (CW'(i) == idx_r) begin
                prc_r[side_r][i] <= p_r;
                vol_r[side_r][i] <= v_r;
              end
            end
            if (n_cur < CW'(LEVEL_DEPTH)) begin
              cnt_r[side_r] <= n_cur + CW'(1);
            end
          end else begin
            // full bid table: insert and drop the lowest level
            for (int i = 0; i < LEVEL_DEPTH; i++) begin
              if (CW'(i + 1) < idx_r) begin
                prc_r[side_r][i] <= prc_up[i];
                vol_r[side_r][i] <= vol_up[i];
              end else if (CW'(i + 1) == idx_r) begin
                prc_r[side_r][i] <= p_r;
                vol_r[side_r][i] <= v_r;
              end
            end
          end
          state_r <= S_DONE;
        end

        // Start work on the next level of a conversion
        S_LEVEL: begin
          if ((left_r == '0) || (lvl_r == '0)) begin
            state_r <= S_DONE;
          end else begin
            lp_r      <= lvl_prc;
            lvl_r     <= lvl_r - CW'(1);
            mul_cnt_r <= '0;
            acc_r     <= '0;
            mul_b_r   <= BW'(lvl_prc);
            state_r   <= S_MUL;
            if (side_r) begin
              idx_r   <= idx_r - CW'(1);
              mul_a_r <= AW'(sell_take);
              left_r  <= left_r - sell_take;
              div_d_r <= BW'(scale_r);
              ret_r   <= S_DIVSTART;
            end else begin
              idx_r   <= idx_r + CW'(1);
              mul_a_r <= AW'(lvl_vol);
              ret_r   <= S_TAKE;
            end
          end
        end

        S_MUL: begin
          acc_r     <= {acc_r[PW-DGW-1:0], {DGW{1'b0}}} + PW'(pp);
          mul_b_r   <= {mul_b_r[BW-DGW-1:0], {DGW{1'b0}}};
          mul_cnt_r <= mul_cnt_r + 2'd1;
          if (mul_cnt_r == 2'(NDG - 1)) begin
            state_r <= ret_r;
          end
        end

        // Buy: clamp take to the level capacity, then take * scale
        S_TAKE: begin
          left_r    <= left_r - buy_take;
          mul_a_r   <= AW'(buy_take);
          mul_b_r   <= BW'(scale_r);
          acc_r     <= '0;
          mul_cnt_r <= '0;
          div_d_r   <= BW'(lp_r);
          ret_r     <= S_DIVSTART;
          state_r   <= S_MUL;
        end

        S_DIVSTART: begin
          if ((div_d_r == '0) || (acc_r[PW-1:AW] >= div_d_r)) begin
            quo_r   <= '1;
            state_r <= S_ACC;
          end else begin
            rem_r     <= acc_r[PW-1:AW];
            num_r     <= acc_r[AW-1:0];
            div_cnt_r <= '0;
            state_r   <= S_DIV;
          end
        end

        S_DIV: begin
          rem_r     <= q_bit ? BW'(trial - {1'b0, div_d_r}) : trial[BW-1:0];
          num_r     <= {num_r[AW-2:0], 1'b0};
          quo_r     <= {quo_r[RECEIVED_W-2:0], q_bit};
          div_cnt_r <= div_cnt_r + 7'd1;
          if (div_cnt_r == 7'(AW - 1)) begin
            state_r <= S_ACC;
          end
        end

        S_ACC: begin
          got_r   <= sum[RECEIVED_W] ? '1 : sum[RECEIVED_W-1:0];
          state_r <= S_LEVEL;
        end

        // Hand the result to the output register once it is free
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_rcv_r   <= conv_r ? got_r : '0;
            out_bid_r   <= LEVELS_W'(cnt_r[1]);
            out_ask_r   <= LEVELS_W'(cnt_r[0]);
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb_top_n_price_level_book_unit.sv
`timescale 1ns / 100ps

module tb_top_n_price_level_book_unit;
  import nplb_pkg::*;

  localparam int DEPTH = LEVEL_DEPTH_DEF;
  localparam logic [63:0] SAT = '1;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [PRICE_W-1:0]  price;
    logic [VOLUME_W-1:0] volume;
    logic [AMOUNT_W-1:0] amount;
  } book_request_t;

  typedef struct packed {
    logic [RECEIVED_W-1:0] received;
    logic [LEVELS_W-1:0]   bid_levels;
    logic [LEVELS_W-1:0]   ask_levels;
  } book_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [SCALE_W-1:0] cfg_wdata;

  nplb_in_if  in_ch ();
  nplb_out_if out_ch ();

  top_n_price_level_book_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the book, sorted by ascending price
  logic [PRICE_W-1:0]  bid_px [DEPTH];
  logic [VOLUME_W-1:0] bid_qty [DEPTH];
  logic [PRICE_W-1:0]  ask_px [DEPTH];
  logic [VOLUME_W-1:0] ask_qty [DEPTH];
  int                  bid_n;
  int                  ask_n;
  logic [SCALE_W-1:0]  scale_shadow;

  book_result_t pending_results [$];
  int           error_count;
  int           burst_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Truncating quotient, saturated to 64 bits; a zero divisor saturates
  function automatic logic [63:0] quot_sat(logic [127:0] num, logic [63:0] den);
    logic [127:0] q;
    if (den == 0) return SAT;
    q = num / den;
    return (q[127:64] != 0) ? SAT : q[63:0];
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = a + b;
    return s[64] ? SAT : s[63:0];
  endfunction

  // Set, insert or remove one level; overflow drops the worst level
  task automatic apply_level(bit is_bid, logic [PRICE_W-1:0] px, logic [VOLUME_W-1:0] qty);
    logic [PRICE_W-1:0]  tp [DEPTH+1];
    logic [VOLUME_W-1:0] tq [DEPTH+1];
    int n, pos, k;
    n = is_bid ? bid_n : ask_n;
    for (int i = 0; i < n; i++) begin
      tp[i] = is_bid ? bid_px[i] : ask_px[i];
      tq[i] = is_bid ? bid_qty[i] : ask_qty[i];
    end
    pos = 0;
    while (pos < n && tp[pos] < px) pos++;
    if (pos < n && tp[pos] == px) begin
      if (qty == 0) begin
        for (int i = pos; i + 1 < n; i++) begin
          tp[i] = tp[i+1];
          tq[i] = tq[i+1];
        end
        k = n - 1;
      end else begin
        tq[pos] = qty;
        k = n;
      end
    end else if (qty == 0) begin
      k = n;
    end else begin
      for (int i = n; i > pos; i--) begin
        tp[i] = tp[i-1];
        tq[i] = tq[i-1];
      end
      tp[pos] = px;
      tq[pos] = qty;
      k = n + 1;
      if (k > DEPTH) begin
        // bids lose the lowest price, asks the highest
        if (is_bid) begin
          for (int i = 0; i < DEPTH; i++) begin
            tp[i] = tp[i+1];
            tq[i] = tq[i+1];
          end
        end
        k = DEPTH;
      end
    end
    for (int i = 0; i < k; i++) begin
      if (is_bid) begin
        bid_px[i] = tp[i];
        bid_qty[i] = tq[i];
      end else begin
        ask_px[i] = tp[i];
        ask_qty[i] = tq[i];
      end
    end
    if (is_bid) bid_n = k;
    else ask_n = k;
  endtask

  // Sell through bids, best (highest) price first
  function automatic logic [63:0] sell_proceeds(logic [63:0] amt);
    logic [63:0] used, got, left, take;
    used = 0;
    got = 0;
    for (int i = bid_n - 1; i >= 0 && used < amt; i--) begin
      left = amt - used;
      take = (64'(bid_qty[i]) < left) ? 64'(bid_qty[i]) : left;
      used += take;
      got = add_sat(got, quot_sat(128'(take) * 128'(bid_px[i]), 64'(scale_shadow)));
    end
    return got;
  endfunction

  // Buy through asks, best (lowest) price first; capacity is volume*price
  function automatic logic [63:0] buy_proceeds(logic [63:0] amt);
    logic [63:0]  used, got, left, take;
    logic [127:0] cap;
    used = 0;
    got = 0;
    for (int i = 0; i < ask_n && used < amt; i++) begin
      left = amt - used;
      cap = 128'(ask_qty[i]) * 128'(ask_px[i]);
      take = (cap > 128'(left)) ? left : cap[63:0];
      used += take;
      got = add_sat(got, quot_sat(128'(take) * 128'(scale_shadow), 64'(ask_px[i])));
    end
    return got;
  endfunction

  task automatic predict_book(book_request_t req);
    book_result_t r;
    r.received = '0;
    case (req.operation)
      OP_ASK_UPD: if (req.price != 0) apply_level(1'b0, req.price, req.volume);
      OP_BID_UPD: if (req.price != 0) apply_level(1'b1, req.price, req.volume);
      OP_SELL:    r.received = sell_proceeds(64'(req.amount));
      OP_BUY:     r.received = buy_proceeds(64'(req.amount));
      default:    r.received = '0;
    endcase
    r.bid_levels = LEVELS_W'(bid_n);
    r.ask_levels = LEVELS_W'(ask_n);
    pending_results.push_back(r);
  endtask

  // Result check first, then prediction of the request taken at this edge
  always @(posedge clk) begin
    book_result_t got, want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.received, out_ch.bid_levels, out_ch.ask_levels};
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.received !== want.received) begin
            $error("received: expected %0d, got %0d", want.received, got.received);
            error_count++;
          end
          if (got.bid_levels !== want.bid_levels) begin
            $error("bid_levels: expected %0d, got %0d", want.bid_levels, got.bid_levels);
            error_count++;
          end
          if (got.ask_levels !== want.ask_levels) begin
            $error("ask_levels: expected %0d, got %0d", want.ask_levels, got.ask_levels);
            error_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_book('{in_ch.operation, in_ch.price, in_ch.volume, in_ch.amount});
    end
  end

  // Receiver stall pattern: rotates through four modes
  int stall_cnt;
  always @(negedge clk) begin
    stall_cnt++;
    case ((stall_cnt / 64) % 4)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = ($urandom_range(0, 1) == 1);
      2: out_ch.ready = (stall_cnt % 5 != 0);
      default: out_ch.ready = ((stall_cnt % 64) > 40);
    endcase
  end

  // Drive one request; called and returning at a falling edge
  task automatic send_request(book_request_t req);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.operation = req.operation;
    in_ch.price = req.price;
    in_ch.volume = req.volume;
    in_ch.amount = req.amount;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_scale(logic [SCALE_W-1:0] value);
    drain_results();
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    scale_shadow = value;
  endtask

  function automatic book_request_t make_req(logic [OP_W-1:0] op, logic [PRICE_W-1:0] px,
                                             logic [VOLUME_W-1:0] qty, logic [AMOUNT_W-1:0] amt);
    return '{op, px, qty, amt};
  endfunction

  // Extremes, empty book, an overflowing bid table, removals, saturation
  task automatic test_directed();
    send_request(make_req(OP_SELL, '0, '0, 63'd1000));
    send_request(make_req(OP_BUY, '0, '0, 63'd1000));
    send_request(make_req(OP_BID_UPD, '0, 48'd500, '0));
    send_request(make_req(OP_ASK_UPD, 48'd700, '0, '0));
    for (int i = 1; i <= DEPTH + 1; i++)
      send_request(make_req(OP_BID_UPD, 48'(i * 100000000), 48'(i * 10), '1));
    send_request(make_req(OP_BID_UPD, 48'd50, 48'd5, '0));
    send_request(make_req(OP_BID_UPD, '1, '1, '0));
    send_request(make_req(OP_SELL, '0, '0, '0));
    send_request(make_req(OP_SELL, '1, '1, '1));
    send_request(make_req(OP_ASK_UPD, '1, '1, '0));
    send_request(make_req(OP_ASK_UPD, 48'd1, 48'd3, '0));
    send_request(make_req(OP_ASK_UPD, 48'd1, 48'd9, '0));
    send_request(make_req(OP_BUY, '0, '0, '1));
    send_request(make_req(OP_BUY, '0, '0, 63'd7));
    send_request(make_req(OP_ASK_UPD, 48'd1, '0, '0));
    send_request(make_req(OP_BID_UPD, 48'd1200000000, '0, '0));
  endtask

  // A zero scale: sells divide by it and saturate, buys multiply by it and give zero
  task automatic test_zero_scale();
    write_scale('0);
    send_request(make_req(OP_SELL, '0, '0, 63'd12345));
    send_request(make_req(OP_BUY, '0, '0, 63'd12345));
    send_request(make_req(OP_ASK_UPD, 48'd2000, 48'd100, '0));
    send_request(make_req(OP_BUY, '0, '0, 63'd50));
  endtask

  function automatic book_request_t random_req();
    book_request_t r;
    int pick;
    r.operation = OP_W'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 5) r.price = '0;
    else if (pick < 15) r.price = 48'({$urandom, $urandom});
    else if (pick < 60) r.price = 48'($urandom_range(1, 24) * 1000);
    else r.price = 48'($urandom_range(1, 30) * 64'd10000000);
    pick = $urandom_range(0, 99);
    if (pick < 15) r.volume = '0;
    else if (pick < 75) r.volume = 48'($urandom_range(1, 100000));
    else r.volume = 48'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 10) r.amount = '0;
    else if (pick < 50) r.amount = 63'($urandom_range(1, 1 << 20));
    else if (pick < 85) r.amount = 63'($urandom);
    else r.amount = 63'({$urandom, $urandom});
    return r;
  endfunction

  task automatic test_random(int count, logic [SCALE_W-1:0] scale);
    write_scale(scale);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 199) == 0) drain_results();
      send_request(random_req());
    end
  endtask

  initial begin : main
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ASK_UPD;
    in_ch.price = '0;
    in_ch.volume = '0;
    in_ch.amount = '0;
    bid_n = 0;
    ask_n = 0;
    scale_shadow = SCALE_RESET;
    error_count = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_zero_scale();
    test_random(400, SCALE_RESET);
    test_random(400, 40'd1000000000000);
    test_random(400, 40'd1);
    test_random(420, 40'd1000);

    drain_results();
    repeat (100) @(negedge clk);
    if (pending_results.size() != 0) error_count++;
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin : watchdog
    #40000000;
    $display("simulation failed");
    $finish;
  end

endmodule
